FILE: sv/fck_pkg.sv
`default_nettype none

package fck_pkg;

	// parse phases of one line
	localparam logic [2:0] PH_LEAD  = 3'd0;
	localparam logic [2:0] PH_TOKEN = 3'd1;
	localparam logic [2:0] PH_GAP   = 3'd2;
	localparam logic [2:0] PH_DIGIT = 3'd3;
	localparam logic [2:0] PH_DONE  = 3'd4;

	// character codes
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] BYTE_LIMIT = 8'd127;

	localparam logic [8:0] MOD255     = 9'd255;
	localparam logic [6:0] TOK_MAX    = 7'd127;
	localparam logic [2:0] PREFIX_LEN = 3'd4;

	// identify prefix, entry 0 is the first character
	localparam logic [3:0][7:0] IDN_WORD = {8'h3F, 8'h4E, 8'h44, 8'h49};

	typedef struct packed {
		logic [15:0] computed_checksum;
		logic [15:0] sent_checksum;
		logic [6:0]  token_length;
		logic        identify_request;
		logic        line_overflow;
	} result_t;

	function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= MOD255) begin
			s = s - MOD255;
		end
		return s[7:0];
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
	endfunction

endpackage

`default_nettype wire

FILE: sv/fck_channels.sv
`default_nettype none

// received byte channel
interface fck_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// per-line result channel
interface fck_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] computed_checksum;
	logic [15:0] sent_checksum;
	logic [6:0]  token_length;
	logic        identify_request;
	logic        line_overflow;

	modport source (output valid, output computed_checksum, output sent_checksum,
		output token_length, output identify_request, output line_overflow, input ready);
	modport sink   (input valid, input computed_checksum, input sent_checksum,
		input token_length, input identify_request, input line_overflow, output ready);
endinterface

`default_nettype wire

FILE: sv/fck_line_state.sv
`default_nettype none

// Per-line parser state: checksum sums, number, counts and prefix match.
module fck_line_state #(
	parameter int MAX_LINE = 128
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  wire logic [7:0]     rx_byte,
	output fck_pkg::result_t    result,
	output logic                line_end
);

	localparam int LCW = $clog2(MAX_LINE);
	localparam logic [LCW-1:0] LINE_LAST = LCW'(MAX_LINE - 1);

	logic [2:0]     phase_q;
	logic [7:0]     sum_lo_q;
	logic [7:0]     sum_hi_q;
	logic [15:0]    num_q;
	logic [6:0]     tok_cnt_q;
	logic [LCW-1:0] line_cnt_q;
	logic [2:0]     pfx_pos_q;
	logic           pfx_match_q;
	logic           ovf_q;

	logic [2:0]     phase_nx;
	logic [7:0]     sum_lo_nx;
	logic [7:0]     sum_hi_nx;
	logic [15:0]    num_nx;
	logic [6:0]     tok_cnt_nx;
	logic [LCW-1:0] line_cnt_nx;
	logic [2:0]     pfx_pos_nx;
	logic           pfx_match_nx;
	logic           ovf_nx;

	logic           keep;
	logic           is_nl;
	logic           full;
	logic           blank;
	logic           digit;
	logic [3:0]     dval;
	logic [7:0]     feed_lo;
	logic [7:0]     feed_hi;
	logic [6:0]     feed_cnt;

	assign keep  = (rx_byte < fck_pkg::BYTE_LIMIT);
	assign is_nl = (rx_byte == fck_pkg::CH_NL);
	assign full  = (line_cnt_q >= LINE_LAST);
	assign blank = fck_pkg::is_blank(rx_byte);
	assign digit = (rx_byte >= fck_pkg::CH_ZERO) && (rx_byte <= fck_pkg::CH_NINE);
	assign dval  = 4'(rx_byte - fck_pkg::CH_ZERO);

	// Fletcher update for a token byte
	assign feed_lo  = fck_pkg::add_mod255(sum_lo_q, rx_byte);
	assign feed_hi  = fck_pkg::add_mod255(sum_hi_q, feed_lo);
	assign feed_cnt = (tok_cnt_q < fck_pkg::TOK_MAX) ? tok_cnt_q + 7'd1 : tok_cnt_q;

	// next state for one kept byte
	always_comb begin
		phase_nx     = phase_q;
		sum_lo_nx    = sum_lo_q;
		sum_hi_nx    = sum_hi_q;
		num_nx       = num_q;
		tok_cnt_nx   = tok_cnt_q;
		line_cnt_nx  = line_cnt_q;
		pfx_pos_nx   = pfx_pos_q;
		pfx_match_nx = pfx_match_q;
		ovf_nx       = ovf_q;
		if (!is_nl && full) begin
			ovf_nx = 1'b1;
		end else begin
			if (!full) begin
				line_cnt_nx = line_cnt_q + LCW'(1);
			end
			if (pfx_pos_q < fck_pkg::PREFIX_LEN) begin
				if (rx_byte != fck_pkg::IDN_WORD[pfx_pos_q[1:0]]) begin
					pfx_match_nx = 1'b0;
				end
				pfx_pos_nx = pfx_pos_q + 3'd1;
			end
			if (rx_byte == fck_pkg::CH_NUL) begin
				phase_nx = fck_pkg::PH_DONE;
			end else begin
				unique case (phase_q)
					fck_pkg::PH_LEAD: begin
						if (!blank) begin
							phase_nx   = fck_pkg::PH_TOKEN;
							sum_lo_nx  = feed_lo;
							sum_hi_nx  = feed_hi;
							tok_cnt_nx = feed_cnt;
						end
					end
					fck_pkg::PH_TOKEN: begin
						if (blank) begin
							phase_nx = fck_pkg::PH_GAP;
						end else begin
							sum_lo_nx  = feed_lo;
							sum_hi_nx  = feed_hi;
							tok_cnt_nx = feed_cnt;
						end
					end
					fck_pkg::PH_GAP: begin
						if (digit) begin
							phase_nx = fck_pkg::PH_DIGIT;
							num_nx   = {12'd0, dval};
						end else if (!blank) begin
							phase_nx = fck_pkg::PH_DONE;
						end
					end
					fck_pkg::PH_DIGIT: begin
						if (digit) begin
							num_nx = {num_q[12:0], 3'b000} + {num_q[14:0], 1'b0} + {12'd0, dval};
						end else begin
							phase_nx = fck_pkg::PH_DONE;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// line result from the updated state
	assign line_end = step && is_nl;
	always_comb begin
		result.computed_checksum = {sum_hi_nx, sum_lo_nx};
		result.sent_checksum     = num_nx;
		result.token_length      = tok_cnt_nx;
		result.identify_request  = pfx_match_nx && (pfx_pos_nx >= fck_pkg::PREFIX_LEN);
		result.line_overflow     = ovf_nx;
	end

	// state registers, cleared at end of line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= fck_pkg::PH_LEAD;
			sum_lo_q    <= '0;
			sum_hi_q    <= '0;
			num_q       <= '0;
			tok_cnt_q   <= '0;
			line_cnt_q  <= '0;
			pfx_pos_q   <= '0;
			pfx_match_q <= 1'b1;
			ovf_q       <= 1'b0;
		end else if (step && keep) begin
			if (is_nl) begin
				phase_q     <= fck_pkg::PH_LEAD;
				sum_lo_q    <= '0;
				sum_hi_q    <= '0;
				num_q       <= '0;
				tok_cnt_q   <= '0;
				line_cnt_q  <= '0;
				pfx_pos_q   <= '0;
				pfx_match_q <= 1'b1;
				ovf_q       <= 1'b0;
			end else begin
				phase_q     <= phase_nx;
				sum_lo_q    <= sum_lo_nx;
				sum_hi_q    <= sum_hi_nx;
				num_q       <= num_nx;
				tok_cnt_q   <= tok_cnt_nx;
				line_cnt_q  <= line_cnt_nx;
				pfx_pos_q   <= pfx_pos_nx;
				pfx_match_q <= pfx_match_nx;
				ovf_q       <= ovf_nx;
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/fck_out_stage.sv
`default_nettype none

// Result register: holds one line result until the sink takes it.
module fck_out_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  wire fck_pkg::result_t data,
	output logic                 can_load,
	fck_result_if.source         res
);

	logic             valid_q;
	fck_pkg::result_t data_q;

	assign can_load = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load) begin
			data_q <= data;
		end
	end

	assign res.valid             = valid_q;
	assign res.computed_checksum = data_q.computed_checksum;
	assign res.sent_checksum     = data_q.sent_checksum;
	assign res.token_length      = data_q.token_length;
	assign res.identify_request  = data_q.identify_request;
	assign res.line_overflow     = data_q.line_overflow;

endmodule

`default_nettype wire

FILE: sv/line_receiver_fletcher_check.sv
`default_nettype none

// Channel  Role  Payload                                          Beat
// rx       sink  rx_byte                                          one serial byte
// res      src   computed_checksum, sent_checksum, token_length,  one result per line
//                identify_request, line_overflow
//
// One byte per cycle sustained. A byte goes into an input register and the parser
// state updates from it when it leaves that register; a newline loads the result
// register on that same edge.
// Reset clears all parser state and both valid flags; no clearing pass.
// Only a newline waiting on a full, stalled result register holds off rx.
module line_receiver_fletcher_check #(
	parameter int MAX_LINE = 128
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	fck_byte_if.sink     rx,
	fck_result_if.source res
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             nl_s1;
	logic             step;
	logic             can_load;
	logic             line_end;
	fck_pkg::result_t line_res;

	assign nl_s1    = (byte_s1 == fck_pkg::CH_NL);
	assign step     = valid_s1 && (!nl_s1 || can_load);
	assign rx.ready = !valid_s1 || step;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	fck_line_state #(
		.MAX_LINE (MAX_LINE)
	) u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.rx_byte  (byte_s1),
		.result   (line_res),
		.line_end (line_end)
	);

	fck_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (line_end),
		.data     (line_res),
		.can_load (can_load),
		.res      (res)
	);

`ifndef SYNTHESIS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> (res.valid && !res.ready))
		else $error("rx stalled without a blocked result");

	a_line_result: assert property (@(posedge clk) disable iff (!arst_n)
		(step && nl_s1) |=> res.valid)
		else $error("newline beat gave no result");

	a_idn_token: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.identify_request) |-> (res.token_length >= 7'd4))
		else $error("identify result with short token");
`endif

endmodule

`default_nettype wire

FILE: tb/fck_checker.sv
`timescale 1ns / 1ps

// Watches both channels, tracks the line parser state from the byte beats and
// compares every result beat against the oldest predicted line result.
module fck_checker #(
	parameter int MAX_LINE = 128
) (
	input  logic  clk,
	input  logic  arst_n,
	fck_byte_if   rx,
	fck_result_if res,
	output int    fail_count,
	output int    pending
);

	// predicted parser state for the current line
	logic [2:0]  phase;
	logic [7:0]  sum_lo;
	logic [7:0]  sum_hi;
	logic [15:0] num_val;
	logic [6:0]  tok_len;
	int          line_len;
	int          pfx_pos;
	logic        pfx_ok;
	logic        ovf;

	// results predicted but not yet seen on the result channel
	fck_pkg::result_t lines_due[$];

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	function automatic logic blank_char(input logic [7:0] b);
		return (b == fck_pkg::CH_SPACE) || (b >= fck_pkg::CH_TAB && b <= fck_pkg::CH_CR);
	endfunction

	function automatic logic [7:0] mod255_add(input logic [7:0] a, input logic [7:0] b);
		int s;
		s = int'(a) + int'(b);
		return 8'(s % 255);
	endfunction

	task automatic clear_line_state();
		phase    = fck_pkg::PH_LEAD;
		sum_lo   = '0;
		sum_hi   = '0;
		num_val  = '0;
		tok_len  = '0;
		line_len = 0;
		pfx_pos  = 0;
		pfx_ok   = 1'b1;
		ovf      = 1'b0;
	endtask

	task automatic take_token_byte(input logic [7:0] b);
		sum_lo = mod255_add(sum_lo, b);
		sum_hi = mod255_add(sum_hi, sum_lo);
		if (tok_len < fck_pkg::TOK_MAX) begin
			tok_len = tok_len + 7'd1;
		end
	endtask

	// token / gap / number parsing of one stored byte
	task automatic advance_parse(input logic [7:0] b);
		logic is_digit;
		is_digit = (b >= fck_pkg::CH_ZERO && b <= fck_pkg::CH_NINE);
		if (b == fck_pkg::CH_NUL) begin
			phase = fck_pkg::PH_DONE;
		end else begin
			case (phase)
				fck_pkg::PH_LEAD: begin
					if (!blank_char(b)) begin
						phase = fck_pkg::PH_TOKEN;
						take_token_byte(b);
					end
				end
				fck_pkg::PH_TOKEN: begin
					if (blank_char(b)) phase = fck_pkg::PH_GAP;
					else take_token_byte(b);
				end
				fck_pkg::PH_GAP: begin
					if (is_digit) begin
						phase   = fck_pkg::PH_DIGIT;
						num_val = 16'(b - fck_pkg::CH_ZERO);
					end else if (!blank_char(b)) begin
						phase = fck_pkg::PH_DONE;
					end
				end
				fck_pkg::PH_DIGIT: begin
					if (is_digit) num_val = 16'(num_val * 10 + 16'(b - fck_pkg::CH_ZERO));
					else phase = fck_pkg::PH_DONE;
				end
				default: ;
			endcase
		end
	endtask

	task automatic predict_byte(input logic [7:0] b);
		fck_pkg::result_t r;
		if (b >= fck_pkg::BYTE_LIMIT) return;
		// buffer full: only a newline still gets through
		if (b != fck_pkg::CH_NL && line_len >= MAX_LINE - 1) begin
			ovf = 1'b1;
			return;
		end
		if (line_len < MAX_LINE - 1) line_len++;
		if (pfx_pos < fck_pkg::PREFIX_LEN) begin
			if (b != fck_pkg::IDN_WORD[pfx_pos]) pfx_ok = 1'b0;
			pfx_pos++;
		end
		advance_parse(b);
		if (b == fck_pkg::CH_NL) begin
			r.computed_checksum = {sum_hi, sum_lo};
			r.sent_checksum     = num_val;
			r.token_length      = tok_len;
			r.identify_request  = pfx_ok && (pfx_pos >= fck_pkg::PREFIX_LEN);
			r.line_overflow     = ovf;
			lines_due.push_back(r);
			clear_line_state();
		end
	endtask

	task automatic check_field(input string what, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		fck_pkg::result_t want;
		if (!arst_n) begin
			clear_line_state();
			lines_due.delete();
			pending = 0;
		end else begin
			// result beat against the oldest line
			if (res.valid && res.ready) begin
				if (lines_due.size() == 0) begin
					$display("%0t: result beat with no line pending, got %h/%h/%0d/%b/%b",
						$time, res.computed_checksum, res.sent_checksum, res.token_length,
						res.identify_request, res.line_overflow);
					fail_count++;
				end else begin
					want = lines_due.pop_front();
					check_field("computed_checksum", want.computed_checksum,
						res.computed_checksum);
					check_field("sent_checksum", want.sent_checksum, res.sent_checksum);
					check_field("token_length", want.token_length, res.token_length);
					check_field("identify_request", want.identify_request,
						res.identify_request);
					check_field("line_overflow", want.line_overflow, res.line_overflow);
				end
			end
			// byte beat into the predictor
			if (rx.valid && rx.ready) begin
				predict_byte(rx.rx_byte);
			end
			pending = lines_due.size();
		end
	end

endmodule

FILE: tb/line_receiver_fletcher_check_test.sv
`timescale 1ns / 1ps

module line_receiver_fletcher_check_test;

	localparam int LINE_MAX        = 128;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int BYTES_PER_PHASE = 520;

	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_BANG  = 8'h21;

	logic       clk = 1'b0;
	logic       arst_n;
	int         snd_idle;
	int         rcv_idle;
	int         cycle_cnt = 0;
	int         fail_count;
	int         pending;
	int         sent_bytes;
	logic [7:0] line_buf[$];

	fck_byte_if   rx_ch();
	fck_result_if res_ch();

	line_receiver_fletcher_check #(
		.MAX_LINE(LINE_MAX)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_ch),
		.res   (res_ch)
	);

	fck_checker #(
		.MAX_LINE(LINE_MAX)
	) checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_ch),
		.res       (res_ch),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("line_receiver_fletcher_check verification failed");
			$finish;
		end
	end

	// result side backpressure
	always @(negedge clk) begin
		res_ch.ready <= arst_n && ($urandom_range(0, 99) >= rcv_idle);
	end

	// one byte beat, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < snd_idle) begin
			rx_ch.valid <= 1'b0;
			@(negedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_line();
		foreach (line_buf[i]) begin
			send_byte(line_buf[i]);
			if (line_buf[i] < fck_pkg::BYTE_LIMIT) sent_bytes++;
		end
		line_buf.delete();
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
	endtask

	task automatic add_blank();
		case ($urandom_range(0, 4))
			0: line_buf.push_back(fck_pkg::CH_TAB);
			1: line_buf.push_back(CH_VT);
			2: line_buf.push_back(CH_FF);
			3: line_buf.push_back(fck_pkg::CH_CR);
			default: line_buf.push_back(fck_pkg::CH_SPACE);
		endcase
	endtask

	// hold the sender until every predicted result has come out
	task automatic drain();
		rx_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	// mostly well-formed lines with random content, some noise and long lines
	task automatic build_random_line();
		int kind;
		int n;
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			n = $urandom_range(0, 14);
			repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
		end else if (kind < 14) begin
			n = $urandom_range(120, 140);
			repeat (n) line_buf.push_back(8'($urandom_range(33, 126)));
		end else begin
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 2)) add_blank();
			end
			if ($urandom_range(0, 4) == 0) add_text("IDN?");
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 10);
			repeat (n) line_buf.push_back(8'($urandom_range(33, 126)));
			if ($urandom_range(0, 9) != 0) begin
				repeat ($urandom_range(1, 2)) add_blank();
				if ($urandom_range(0, 7) == 0) add_text($urandom_range(0, 1) ? "+" : "-");
				repeat ($urandom_range(0, 7))
					line_buf.push_back(fck_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
				if ($urandom_range(0, 3) == 0) begin
					line_buf.push_back(8'($urandom_range(33, 126)));
					repeat ($urandom_range(0, 3))
						line_buf.push_back(fck_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
				end
			end
			if ($urandom_range(0, 11) == 0)
				line_buf.insert($urandom_range(0, line_buf.size()), fck_pkg::CH_NUL);
			if ($urandom_range(0, 11) == 0)
				line_buf.insert($urandom_range(0, line_buf.size()), 8'($urandom_range(127, 255)));
		end
		line_buf.push_back(fck_pkg::CH_NL);
	endtask

	task automatic directed_lines();
		add_text("IDN?\n");
		send_line();
		add_text("  ab 65535\n");
		send_line();
		add_text("x 65536\n");
		send_line();
		add_text("q 4294967295\n");
		send_line();
		// empty line
		line_buf.push_back(fck_pkg::CH_NL);
		send_line();
		// too short to identify
		add_text("ID\n");
		send_line();
		add_text("tok -5\n");
		send_line();
		add_text("a 12z9\n");
		send_line();
		// NUL ends the parsed text
		add_text("ab");
		line_buf.push_back(fck_pkg::CH_NUL);
		add_text("cd 5\n");
		send_line();
		// NUL inside the identify prefix
		add_text("ID");
		line_buf.push_back(fck_pkg::CH_NUL);
		add_text("N? 7\n");
		send_line();
		// dropped bytes inside a line
		add_text("k");
		line_buf.push_back(8'hFF);
		line_buf.push_back(fck_pkg::BYTE_LIMIT);
		add_text(" 4");
		line_buf.push_back(8'h80);
		add_text("2\n");
		send_line();
		// whitespace only
		line_buf.push_back(fck_pkg::CH_TAB);
		line_buf.push_back(fck_pkg::CH_SPACE);
		line_buf.push_back(CH_VT);
		line_buf.push_back(CH_FF);
		line_buf.push_back(fck_pkg::CH_CR);
		line_buf.push_back(fck_pkg::CH_SPACE);
		line_buf.push_back(fck_pkg::CH_NL);
		send_line();
		// buffer filled exactly, longest token
		repeat (LINE_MAX - 1) line_buf.push_back(CH_TILDE);
		line_buf.push_back(fck_pkg::CH_NL);
		send_line();
		// buffer overflow
		repeat (LINE_MAX + 2) line_buf.push_back(CH_BANG);
		add_text(" 9\n");
		send_line();
	endtask

	task automatic random_phase();
		sent_bytes = 0;
		while (sent_bytes < BYTES_PER_PHASE) begin
			build_random_line();
			send_line();
		end
		drain();
	endtask

	initial begin
		arst_n        = 1'b0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		res_ch.ready  = 1'b0;
		snd_idle      = 29;
		rcv_idle      = 61;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed_lines();
		drain();
		random_phase();

		snd_idle = 61;
		rcv_idle = 29;
		random_phase();

		snd_idle = 0;
		rcv_idle = 0;
		random_phase();

		repeat (8) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("line_receiver_fletcher_check verification clean");
		end else begin
			$display("line_receiver_fletcher_check verification failed");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/fck_pkg.sv
sv/fck_channels.sv
sv/fck_line_state.sv
sv/fck_out_stage.sv
sv/line_receiver_fletcher_check.sv
tb/fck_checker.sv
tb/line_receiver_fletcher_check_test.sv
